[rtl/core/quad_serial_adc_reader_core_assert.svh]
// assertion macros for the quad serial adc reader core
`ifndef QUAD_SERIAL_ADC_READER_CORE_ASSERT_SVH
`define QUAD_SERIAL_ADC_READER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define QSAR_ASSERT_IMPLIES(label, clk_sig, rst_sig, lhs, rhs) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (lhs) |-> (rhs)) \
        else $error("assertion failed");

`define QSAR_ASSERT_NEXT(label, clk_sig, rst_sig, lhs, rhs) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`else

`define QSAR_ASSERT_IMPLIES(label, clk_sig, rst_sig, lhs, rhs)

`define QSAR_ASSERT_NEXT(label, clk_sig, rst_sig, lhs, rhs)

`endif

`endif

[rtl/core/qsar_pkg.sv]
// shared types and constants of the quad serial adc reader
package qsar_pkg;

    localparam int unsigned OUT_BITS    = 12;
    localparam int unsigned PIN_COUNT   = 4;
    localparam int unsigned PERIOD_BITS = 16;
    localparam int unsigned WAIT_BITS   = 18;
    localparam int unsigned ADDR_BITS   = 3;
    localparam int unsigned DATA_BITS   = 32;
    localparam int unsigned HOLD_PHASES_LOG2 = 2;

    localparam logic [PERIOD_BITS-1:0] HALF_PERIOD_RESET    = 16'd16;
    localparam logic [PIN_COUNT-1:0]   CHANNEL_ENABLE_RESET = 4'hF;

    typedef enum logic {
        REG_HALF_PERIOD    = 1'b0,
        REG_CHANNEL_ENABLE = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CLOCK = 2'd1,
        PH_TAIL  = 2'd2,
        PH_HOLD  = 2'd3
    } phase_t;

    typedef struct packed {
        logic clear;
        logic shift;
        logic latch;
    } seq_ctrl_t;

    typedef struct packed {
        logic serial_clock;
        logic chip_select_n;
        logic busy;
        logic done;
    } seq_stat_t;

endpackage

[rtl/core/qsar_if.sv]
// transaction channels of the quad serial adc reader
interface qsar_in_if;
    logic                               valid;
    logic                               ready;
    logic                               start_req;
    logic [qsar_pkg::PIN_COUNT-1:0]     data_pins;

    modport source (output valid, output start_req, output data_pins, input ready);
    modport sink (input valid, input start_req, input data_pins, output ready);
endinterface

interface qsar_out_if;
    logic                               valid;
    logic                               ready;
    logic                               serial_clock;
    logic                               chip_select_n;
    logic                               busy_res;
    logic                               done_res;
    logic [qsar_pkg::OUT_BITS-1:0]      sample_one;
    logic [qsar_pkg::OUT_BITS-1:0]      sample_two;
    logic [qsar_pkg::OUT_BITS-1:0]      sample_three;
    logic [qsar_pkg::OUT_BITS-1:0]      sample_four;

    modport source (
        output valid, output serial_clock, output chip_select_n, output busy_res,
        output done_res, output sample_one, output sample_two, output sample_three,
        output sample_four, input ready
    );
    modport sink (
        input valid, input serial_clock, input chip_select_n, input busy_res,
        input done_res, input sample_one, input sample_two, input sample_three,
        input sample_four, output ready
    );
endinterface

[rtl/core/quad_serial_adc_reader_core.sv]
// quad serial adc reader: one input transaction per tick, one result per tick
// a result is registered in the cycle after its input transaction is accepted
// throughput: one transaction per cycle while the result side is ready, set by the single result register stage
// the sequencer timing counts accepted transactions, not clock cycles
// reset: sequencer idle, chip select high, clock low, lane samples zero, half period 16, all channels on
module quad_serial_adc_reader_core #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned CHANNELS    = 4,
    parameter int unsigned LEAD_PULSES = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    qsar_in_if.sink                           in_ch,
    qsar_out_if.source                        out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qsar_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [qsar_pkg::DATA_BITS-1:0]    pwdata,
    output logic [qsar_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready
);
    import qsar_pkg::*;

    `include "quad_serial_adc_reader_core_assert.svh"

    localparam int unsigned LANES = (CHANNELS < PIN_COUNT) ? CHANNELS : PIN_COUNT;

    logic [PERIOD_BITS-1:0] half_period;
    logic [PIN_COUNT-1:0]   channel_enable;
    logic                   step;
    seq_ctrl_t              ctrl;
    seq_stat_t              stat;
    logic [OUT_BITS-1:0]    sample_next [PIN_COUNT];

    logic                   out_valid_reg, out_valid_next;
    seq_stat_t              stat_reg;
    logic [OUT_BITS-1:0]    sample_reg [PIN_COUNT];

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign step        = in_ch.valid && in_ch.ready;

    qsar_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .half_period    (half_period),
        .channel_enable (channel_enable)
    );

    qsar_seq #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEAD_PULSES (LEAD_PULSES)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .start_req   (in_ch.start_req),
        .half_period (half_period),
        .ctrl        (ctrl),
        .stat        (stat)
    );

    for (genvar k = 0; k < PIN_COUNT; k++)
    begin : g_lane
        if (k < LANES)
        begin : g_on
            logic [SAMPLE_BITS-1:0] held_next;

            qsar_lane #(
                .SAMPLE_BITS (SAMPLE_BITS)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .enable    (channel_enable[k]),
                .pin       (in_ch.data_pins[k]),
                .held_next (held_next)
            );

            assign sample_next[k] = OUT_BITS'(held_next);
        end
        else
        begin : g_off
            assign sample_next[k] = '0;
        end
    end

    assign out_valid_next = step || (out_valid_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            stat_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                stat_reg <= stat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            sample_reg <= sample_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.serial_clock  = stat_reg.serial_clock;
    assign out_ch.chip_select_n = stat_reg.chip_select_n;
    assign out_ch.busy_res      = stat_reg.busy;
    assign out_ch.done_res      = stat_reg.done;
    assign out_ch.sample_one    = sample_reg[0];
    assign out_ch.sample_two    = sample_reg[1];
    assign out_ch.sample_three  = sample_reg[2];
    assign out_ch.sample_four   = sample_reg[3];

    // the serial clock only runs while the converters are selected
    `QSAR_ASSERT_IMPLIES(a_clock_needs_select, clk, rst_n,
        out_valid_reg && stat_reg.serial_clock, !stat_reg.chip_select_n)
    // the done transaction leaves the bus idle
    `QSAR_ASSERT_IMPLIES(a_done_idle, clk, rst_n,
        out_valid_reg && stat_reg.done,
        stat_reg.chip_select_n && !stat_reg.serial_clock && !stat_reg.busy)
    // a sequence only ends through done
    `QSAR_ASSERT_IMPLIES(a_busy_ends_with_done, clk, rst_n,
        $fell(stat_reg.busy), stat_reg.done)

endmodule

[rtl/core/qsar_cfg.sv]
// apb configuration registers
module qsar_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qsar_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [qsar_pkg::DATA_BITS-1:0]    pwdata,
    output logic [qsar_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready,
    output logic [qsar_pkg::PERIOD_BITS-1:0]  half_period,
    output logic [qsar_pkg::PIN_COUNT-1:0]    channel_enable
);
    import qsar_pkg::*;

    logic [PERIOD_BITS-1:0] half_period_reg;
    logic [PIN_COUNT-1:0]   channel_enable_reg;
    logic                   wr_en;
    reg_index_t             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg    <= HALF_PERIOD_RESET;
            channel_enable_reg <= CHANNEL_ENABLE_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_HALF_PERIOD:    half_period_reg    <= pwdata[PERIOD_BITS-1:0];
                REG_CHANNEL_ENABLE: channel_enable_reg <= pwdata[PIN_COUNT-1:0];
                default:            half_period_reg    <= half_period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_HALF_PERIOD:    prdata = DATA_BITS'(half_period_reg);
            REG_CHANNEL_ENABLE: prdata = DATA_BITS'(channel_enable_reg);
            default:            prdata = '0;
        endcase
    end

    assign half_period    = half_period_reg;
    assign channel_enable = channel_enable_reg;

endmodule

[rtl/core/qsar_seq.sv]
// conversion timing sequencer
module qsar_seq #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned LEAD_PULSES = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic                              start_req,
    input  logic [qsar_pkg::PERIOD_BITS-1:0]  half_period,
    output qsar_pkg::seq_ctrl_t               ctrl,
    output qsar_pkg::seq_stat_t               stat
);
    import qsar_pkg::*;

    localparam int unsigned EDGE_TOTAL = LEAD_PULSES + SAMPLE_BITS;
    localparam int unsigned EDGE_BITS  = $clog2(EDGE_TOTAL + 1);

    phase_t                 phase_reg, phase_next;
    logic [WAIT_BITS-1:0]   wait_reg, wait_next;
    logic [EDGE_BITS-1:0]   edge_reg, edge_next;
    logic                   clock_reg, clock_next;
    logic                   select_reg, select_next;

    logic [PERIOD_BITS-1:0] phase_len;
    logic [WAIT_BITS-1:0]   wait_inc;
    logic [EDGE_BITS-1:0]   edge_inc;
    logic                   phase_end;
    logic                   hold_end;
    logic                   last_edge;

    assign phase_len = (half_period == '0) ? PERIOD_BITS'(1) : half_period;
    assign wait_inc  = wait_reg + 1'b1;
    assign edge_inc  = edge_reg + 1'b1;
    assign phase_end = wait_inc >= WAIT_BITS'(phase_len);
    assign hold_end  = wait_inc >= {phase_len, HOLD_PHASES_LOG2'(0)};
    assign last_edge = edge_inc >= EDGE_BITS'(EDGE_TOTAL);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            case (phase_reg)
                PH_IDLE:  if (start_req) phase_next = PH_CLOCK;
                PH_CLOCK: if (phase_end && !clock_reg && last_edge) phase_next = PH_TAIL;
                PH_TAIL:  if (phase_end) phase_next = PH_HOLD;
                PH_HOLD:  if (hold_end) phase_next = PH_IDLE;
                default:  phase_next = PH_IDLE;
            endcase
        end
    end

    // counters, pin levels and lane strobes
    always_comb
    begin
        wait_next   = wait_reg;
        edge_next   = edge_reg;
        clock_next  = clock_reg;
        select_next = select_reg;
        ctrl        = '0;
        stat.done   = 1'b0;
        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start_req)
                    begin
                        wait_next   = '0;
                        edge_next   = '0;
                        clock_next  = 1'b0;
                        select_next = 1'b0;
                        ctrl.clear  = 1'b1;
                    end
                end
                PH_CLOCK:
                begin
                    if (phase_end)
                    begin
                        wait_next  = '0;
                        clock_next = !clock_reg;
                        if (!clock_reg)
                        begin
                            ctrl.shift = edge_reg >= EDGE_BITS'(LEAD_PULSES);
                            edge_next  = edge_inc;
                        end
                    end
                    else
                    begin
                        wait_next = wait_inc;
                    end
                end
                PH_TAIL:
                begin
                    if (phase_end)
                    begin
                        wait_next   = '0;
                        clock_next  = 1'b0;
                        select_next = 1'b1;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                    end
                end
                PH_HOLD:
                begin
                    if (hold_end)
                    begin
                        wait_next  = '0;
                        ctrl.latch = 1'b1;
                        stat.done  = 1'b1;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                    end
                end
                default:
                begin
                    wait_next = '0;
                end
            endcase
        end
        stat.serial_clock  = clock_next;
        stat.chip_select_n = select_next;
        stat.busy          = phase_next != PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            wait_reg   <= '0;
            edge_reg   <= '0;
            clock_reg  <= 1'b0;
            select_reg <= 1'b1;
        end
        else
        begin
            phase_reg  <= phase_next;
            wait_reg   <= wait_next;
            edge_reg   <= edge_next;
            clock_reg  <= clock_next;
            select_reg <= select_next;
        end
    end

endmodule

[rtl/core/qsar_lane.sv]
// one channel: shift register and held sample
module qsar_lane #(
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  qsar_pkg::seq_ctrl_t     ctrl,
    input  logic                    enable,
    input  logic                    pin,
    output logic [SAMPLE_BITS-1:0]  held_next
);
    import qsar_pkg::*;

    logic [SAMPLE_BITS-1:0] shift_reg, shift_next;
    logic [SAMPLE_BITS-1:0] held_reg;

    always_comb
    begin
        shift_next = shift_reg;
        if (ctrl.clear)
        begin
            shift_next = '0;
        end
        else if (ctrl.shift && enable)
        begin
            // msb first
            shift_next = SAMPLE_BITS'({shift_reg, pin});
        end
    end

    assign held_next = ctrl.latch ? shift_reg : held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            shift_reg <= shift_next;
            held_reg  <= held_next;
        end
    end

endmodule

[tb/quad_serial_adc_reader_core_tb.sv]
// testbench of the quad serial adc reader core: per-tick sequencer prediction checked under random stalls
module quad_serial_adc_reader_core_tb;
    import qsar_pkg::*;

    localparam int unsigned SAMPLE_BITS = OUT_BITS;
    localparam int unsigned LEAD_PULSES = 3;
    localparam int unsigned HOLD_PHASES = 1 << HOLD_PHASES_LOG2;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_CHUNKS = 6;
    localparam int unsigned CHUNK_TICKS = 45;

    typedef struct packed {
        logic                               sclk;
        logic                               cs_n;
        logic                               busy;
        logic                               done;
        logic [PIN_COUNT-1:0][OUT_BITS-1:0] samples;
    } adc_levels_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    qsar_in_if  tick_bus ();
    qsar_out_if level_bus ();

    quad_serial_adc_reader_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (tick_bus),
        .out_ch  (level_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // sequencer prediction state
    logic [PERIOD_BITS-1:0]             cfg_half_period;
    logic [PIN_COUNT-1:0]               cfg_enable;
    phase_t                             seq_phase;
    logic [WAIT_BITS-1:0]               tick_count;
    logic [3:0]                         edges_seen;
    logic                               sclk_level;
    logic                               cs_level;
    logic [PIN_COUNT-1:0][OUT_BITS-1:0] shift_words;
    logic [PIN_COUNT-1:0][OUT_BITS-1:0] held_words;

    adc_levels_t expected_levels[$];

    bit          gaps_on;
    int unsigned fail_count;
    int unsigned ticks_sent;
    int unsigned levels_checked;
    int unsigned conversions_done;
    int unsigned register_writes;
    int unsigned cycle_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void step_sequencer(input logic start, input logic [PIN_COUNT-1:0] pins);
        int unsigned len;
        adc_levels_t lv;
        len = (cfg_half_period == '0) ? 1 : int'(cfg_half_period);
        lv.done = 1'b0;
        case (seq_phase)
            PH_IDLE:
            begin
                if (start)
                begin
                    seq_phase   = PH_CLOCK;
                    tick_count  = '0;
                    edges_seen  = '0;
                    sclk_level  = 1'b0;
                    cs_level    = 1'b0;
                    shift_words = '0;
                end
            end
            PH_CLOCK:
            begin
                tick_count++;
                if (tick_count >= len)
                begin
                    tick_count = '0;
                    sclk_level = ~sclk_level;
                    if (sclk_level)
                    begin
                        if (edges_seen >= LEAD_PULSES)
                        begin
                            for (int k = 0; k < PIN_COUNT; k++)
                            begin
                                if (cfg_enable[k])
                                    shift_words[k] = {shift_words[k][SAMPLE_BITS-2:0], pins[k]};
                            end
                        end
                        edges_seen++;
                        if (edges_seen >= LEAD_PULSES + SAMPLE_BITS)
                            seq_phase = PH_TAIL;
                    end
                end
            end
            PH_TAIL:
            begin
                tick_count++;
                if (tick_count >= len)
                begin
                    tick_count = '0;
                    sclk_level = 1'b0;
                    cs_level   = 1'b1;
                    seq_phase  = PH_HOLD;
                end
            end
            default:
            begin
                tick_count++;
                if (tick_count >= HOLD_PHASES * len)
                begin
                    tick_count = '0;
                    held_words = shift_words;
                    lv.done    = 1'b1;
                    seq_phase  = PH_IDLE;
                    conversions_done++;
                end
            end
        endcase
        lv.sclk    = sclk_level;
        lv.cs_n    = cs_level;
        lv.busy    = (seq_phase != PH_IDLE);
        lv.samples = held_words;
        expected_levels.push_back(lv);
    endfunction

    function automatic void compare_level(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result side: random stall bursts
    initial
    begin
        int unsigned hold;
        hold = 0;
        level_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
            begin
                hold--;
                level_bus.ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(1, 18) - 1;
                level_bus.ready <= 1'b0;
            end
            else
                level_bus.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_levels
        adc_levels_t want;
        if (rst_n && level_bus.valid && level_bus.ready)
        begin
            if (expected_levels.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                fail_count++;
            end
            else
            begin
                want = expected_levels.pop_front();
                compare_level("serial_clock", want.sclk, level_bus.serial_clock);
                compare_level("chip_select_n", want.cs_n, level_bus.chip_select_n);
                compare_level("busy_res", want.busy, level_bus.busy_res);
                compare_level("done_res", want.done, level_bus.done_res);
                compare_level("sample_one", want.samples[0], level_bus.sample_one);
                compare_level("sample_two", want.samples[1], level_bus.sample_two);
                compare_level("sample_three", want.samples[2], level_bus.sample_three);
                compare_level("sample_four", want.samples[3], level_bus.sample_four);
                levels_checked++;
            end
        end
    end

    task automatic send_tick(input logic start, input logic [PIN_COUNT-1:0] pins);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            tick_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        tick_bus.valid     <= 1'b1;
        tick_bus.start_req <= start;
        tick_bus.data_pins <= pins;
        @(posedge clk);
        while (!tick_bus.ready) @(posedge clk);
        step_sequencer(start, pins);
        ticks_sent++;
    endtask

    task automatic wait_for_results();
        tick_bus.valid <= 1'b0;
        do @(posedge clk); while (expected_levels.size() != 0);
    endtask

    task automatic write_register(input reg_index_t idx, input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HALF_PERIOD:    cfg_half_period = value[PERIOD_BITS-1:0];
            REG_CHANNEL_ENABLE: cfg_enable      = value[PIN_COUNT-1:0];
            default:            ;
        endcase
        register_writes++;
        @(posedge clk);
    endtask

    // start held high throughout, so starts while busy and on the done tick are ignored
    task automatic run_conversion(input logic [PIN_COUNT-1:0] pins, input bit scramble);
        int unsigned target;
        target = conversions_done + 1;
        while (conversions_done < target)
            send_tick(1'b1, scramble ? PIN_COUNT'($urandom_range(0, 15)) : pins);
    endtask

    task automatic test_idle_outputs();
        repeat (4) send_tick(1'b0, PIN_COUNT'($urandom_range(0, 15)));
    endtask

    task automatic test_full_scale_samples();
        wait_for_results();
        // zero half period acts as one
        write_register(REG_HALF_PERIOD, '0);
        run_conversion('1, 1'b0);
        run_conversion('0, 1'b0);
        send_tick(1'b0, '1);
    endtask

    task automatic test_disabled_channels();
        wait_for_results();
        write_register(REG_CHANNEL_ENABLE, '0);
        run_conversion('1, 1'b0);
        wait_for_results();
        write_register(REG_CHANNEL_ENABLE, 32'h5);
        run_conversion('0, 1'b1);
    endtask

    task automatic test_period_extremes();
        wait_for_results();
        write_register(REG_CHANNEL_ENABLE, 32'hF);
        write_register(REG_HALF_PERIOD, 32'hFFFF);
        repeat (6) send_tick(1'b1, PIN_COUNT'($urandom_range(0, 15)));
        // shortened mid-phase, the phase ends on the next tick
        wait_for_results();
        write_register(REG_HALF_PERIOD, 32'd1);
        run_conversion('0, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned hp;
        for (int chunk = 0; chunk < RANDOM_CHUNKS; chunk++)
        begin
            gaps_on = (chunk != 2) && (chunk != RANDOM_CHUNKS - 1);
            // settings change here, often mid-conversion
            wait_for_results();
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       hp = 0;
                    1:       hp = $urandom_range(4, 6);
                    default: hp = $urandom_range(1, 3);
                endcase
                write_register(REG_HALF_PERIOD, DATA_BITS'(hp));
            end
            else
                write_register(REG_CHANNEL_ENABLE, DATA_BITS'($urandom_range(0, 15)));
            if ($urandom_range(0, 1) != 0)
                write_register(REG_CHANNEL_ENABLE, DATA_BITS'($urandom_range(0, 15)));
            repeat (CHUNK_TICKS)
                send_tick($urandom_range(0, 3) == 0, PIN_COUNT'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        tick_bus.valid     <= 1'b0;
        tick_bus.start_req <= 1'b0;
        tick_bus.data_pins <= '0;
        cfg_half_period  = HALF_PERIOD_RESET;
        cfg_enable       = CHANNEL_ENABLE_RESET;
        seq_phase        = PH_IDLE;
        tick_count       = '0;
        edges_seen       = '0;
        sclk_level       = 1'b0;
        cs_level         = 1'b1;
        shift_words      = '0;
        held_words       = '0;
        gaps_on          = 1'b1;
        fail_count       = 0;
        ticks_sent       = 0;
        levels_checked   = 0;
        conversions_done = 0;
        register_writes  = 0;
        cycle_count      = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_outputs();
        test_full_scale_samples();
        test_disabled_channels();
        test_period_extremes();
        test_random_traffic();

        wait_for_results();
        repeat (4) @(posedge clk);
        $display("covered %0d ticks and %0d checked results, %0d completed conversions",
                 ticks_sent, levels_checked, conversions_done);
        $display("with %0d register writes across period and channel mask settings",
                 register_writes);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/qsar_pkg.sv
rtl/core/qsar_if.sv
rtl/core/qsar_cfg.sv
rtl/core/qsar_seq.sv
rtl/core/qsar_lane.sv
rtl/core/quad_serial_adc_reader_core.sv
tb/quad_serial_adc_reader_core_tb.sv
